// ===== hw/rtl/tropo_mapping_function_macros.svh =====
// Assertion helpers for the top RTL file of the mapping function block.
`ifndef TROPO_MAPPING_FUNCTION_MACROS_SVH
`define TROPO_MAPPING_FUNCTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmf_pkg.sv =====
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 18;
    localparam int OUT_W         = 22;

    // Pipeline depth of one mapping lane
    localparam int SQRT_STEPS = 32;
    localparam int SIN_STEPS  = 7;
    localparam int DIV_STEPS  = 22;
    localparam int LANE_LAT   = SQRT_STEPS + 2 + 2 * SIN_STEPS + 2 + DIV_STEPS;

    // pi in Q32 and Q30
    localparam logic [63:0] PI_Q32      = 64'd13493037705;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = PI_Q30 >> 1;

    // Squared offset angles (pi/72 dry, pi/120 wet) in Q60
    localparam logic [63:0] A_DRY  = (PI_Q32 + 64'd36) / 64'd72;
    localparam logic [63:0] A2_DRY = (A_DRY * A_DRY + 64'd8) >> 4;
    localparam logic [63:0] A_WET  = (PI_Q32 + 64'd60) / 64'd120;
    localparam logic [63:0] A2_WET = (A_WET * A_WET + 64'd8) >> 4;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Height limits in meters
    localparam logic signed [IN_W-1:0] H_MIN = -18'sd1000;
    localparam logic signed [IN_W-1:0] H_MAX = 18'sd20000;

    // Taylor divisors of the nested sine series, innermost first
    function automatic int unsigned sin_div(input int idx);
        int unsigned k;
        unique case (idx)
            0:       k = 210;
            1:       k = 156;
            2:       k = 110;
            3:       k = 72;
            4:       k = 42;
            5:       k = 20;
            default: k = 6;
        endcase
        return k;
    endfunction

    // Data handed between sine cells
    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
    } sin_item_t;

endpackage

// ===== hw/rtl/tropo_mapping_function.sv =====
`timescale 1ns / 1ps

// Tropospheric mapping factors (dry and wet) from elevation and height.
// Input stream s_axis: one request carries elevation (Q1.16 rad) and height
// in meters. Output stream m_axis: dry and wet factors (Q(22-FRAC_BITS).FRAC_BITS,
// clamped) in tdata, the in-range flag in tuser. Out-of-range heights give zeros.
// Stages: the factors pass 75 register stages: 2 input stages; 72 lane
// stages made of 32 square root cells, 2 fold stages, 14 sine stages, 2
// divider setup stages and 22 divider cells; then the output register.
// Throughput: one request per cycle while the chain is not held; every
// stage is a cell of a chain that advances together.
// Stalls: while the output register holds a request not yet taken, the
// chain still advances as long as its last stage is empty, so bubbles are
// squeezed out; once the last stage is full, the whole chain and s_axis_tready hold.
// Reset: all valid bits and the output valid clear; payload is not reset.
`include "tropo_mapping_function_macros.svh"

module tropo_mapping_function #(
    parameter int FRAC_BITS = tmf_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // elevation[17:0], height_m[35:18], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // dry_mapping[21:0], wet_mapping[43:22], zero pad
    output logic        m_axis_tuser    // in_range
);

    localparam int PIPE_LEN = 2 + tmf_pkg::LANE_LAT;

    logic                             en;
    logic                             load;
    logic [PIPE_LEN-1:0]              vld_reg;
    logic [PIPE_LEN-1:0]              vld_next;
    logic [PIPE_LEN-1:0]              inr_reg;
    logic signed [tmf_pkg::IN_W-1:0]  el;
    logic signed [tmf_pkg::IN_W-1:0]  hgt;
    logic [tmf_pkg::IN_W-1:0]         mag;
    logic [tmf_pkg::IN_W-1:0]         mag_reg;
    logic [35:0]                      elsq_reg;
    logic [tmf_pkg::OUT_W-1:0]        dry_map;
    logic [tmf_pkg::OUT_W-1:0]        wet_map;
    logic [tmf_pkg::OUT_W-1:0]        dry_reg;
    logic [tmf_pkg::OUT_W-1:0]        wet_reg;
    logic                             out_inr_reg;
    logic                             out_vld_reg;
    logic                             out_vld_next;

    // Chain advances unless its last request is blocked by the output
    assign en   = !vld_reg[PIPE_LEN-1] || !out_vld_reg || m_axis_tready;
    assign load = en && vld_reg[PIPE_LEN-1];

    assign s_axis_tready = en;

    // Input decode: magnitude and height check
    assign el  = s_axis_tdata[17:0];
    assign hgt = s_axis_tdata[35:18];
    assign mag = el[tmf_pkg::IN_W-1] ? (~el + 18'd1) : el;

    assign vld_next = {vld_reg[PIPE_LEN-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload of the input stages and the in-range delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag;
            elsq_reg <= {18'd0, mag_reg} * {18'd0, mag_reg};
            inr_reg  <= {inr_reg[PIPE_LEN-2:0], (hgt >= tmf_pkg::H_MIN) && (hgt <= tmf_pkg::H_MAX)};
        end
    end

    tmf_lane #(.FRAC_BITS(FRAC_BITS), .A2(tmf_pkg::A2_DRY)) u_dry (
        .clk     (clk),
        .en      (en),
        .el_sq   (elsq_reg),
        .mapping (dry_map)
    );

    tmf_lane #(.FRAC_BITS(FRAC_BITS), .A2(tmf_pkg::A2_WET)) u_wet (
        .clk     (clk),
        .en      (en),
        .el_sq   (elsq_reg),
        .mapping (wet_map)
    );

    // Output register
    always_comb
    begin
        if (load)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dry_reg     <= inr_reg[PIPE_LEN-1] ? dry_map : '0;
            wet_reg     <= inr_reg[PIPE_LEN-1] ? wet_map : '0;
            out_inr_reg <= inr_reg[PIPE_LEN-1];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, wet_reg, dry_reg};
    assign m_axis_tuser  = out_inr_reg;

    // Checks
    `TMF_ASSERT_IMP(a_zero_when_out, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "out-of-range request with nonzero factors")
    `TMF_ASSERT_IMP(a_nonzero_when_in, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[21:0] != '0) && (m_axis_tdata[43:22] != '0), "in-range request with zero factor")
    `TMF_ASSERT_IMP(a_ready_when_empty, !vld_reg[PIPE_LEN-1], s_axis_tready, "chain stalled with empty last stage")
    `TMF_ASSERT_NXT(a_load_gives_valid, s_axis_tready && vld_reg[PIPE_LEN-1], m_axis_tvalid, "finished request lost at output")

endmodule

// ===== hw/rtl/tmf_sqrt_cell.sv =====
`timescale 1ns / 1ps

// One digit of the bitwise integer square root
module tmf_sqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v_in,
    input  logic [63:0] r_in,
    output logic [63:0] v_reg,
    output logic [63:0] r_reg
);

    logic [63:0] trial;
    logic [63:0] v_next;
    logic [63:0] r_next;

    // Trial subtract of r + bit
    always_comb
    begin
        trial = r_in + (64'd1 << BIT_POS);
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + (64'd1 << BIT_POS);
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

endmodule

// ===== hw/rtl/tmf_sin_cell.sv =====
`timescale 1ns / 1ps

// One term of the nested sine series: t = 1 - x2*t/K, two register stages
module tmf_sin_cell #(
    parameter int unsigned DIV_K = 6
) (
    input  logic               clk,
    input  logic               en,
    input  tmf_pkg::sin_item_t item_in,
    output tmf_pkg::sin_item_t item_reg
);

    // Reciprocal for exact division of a 32-bit value by DIV_K
    localparam int          SH    = 32 + $clog2(DIV_K);
    localparam logic [64:0] RECIP = ((65'd1 << SH) + 65'(DIV_K) - 65'd1) / 65'(DIV_K);

    tmf_pkg::sin_item_t a_reg;
    logic [31:0]        p_reg;
    logic [62:0]        prod_a;
    logic [64:0]        prod_b;
    logic [64:0]        quo;
    logic [30:0]        t_next;

    // Stage a: x2 * t in Q30
    assign prod_a = {31'd0, item_in.x2} * {32'd0, item_in.t};

    // Stage b: divide by K and subtract from one
    assign prod_b = {33'd0, p_reg} * RECIP;
    assign quo    = prod_b >> SH;
    assign t_next = (31'd1 << 30) - quo[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= item_in;
            p_reg      <= prod_a[61:30];
            item_reg.x  <= a_reg.x;
            item_reg.x2 <= a_reg.x2;
            item_reg.t  <= t_next;
        end
    end

endmodule

// ===== hw/rtl/tmf_div_cell.sv =====
`timescale 1ns / 1ps

// One quotient bit of the restoring reciprocal divider
module tmf_div_cell #(
    parameter int DW = 54,
    parameter int SH = 21
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [DW-1:0]             rem_in,
    input  logic [30:0]               den_in,
    input  logic [tmf_pkg::OUT_W-1:0] quo_in,
    input  logic                      ovf_in,
    output logic [DW-1:0]             rem_reg,
    output logic [30:0]               den_reg,
    output logic [tmf_pkg::OUT_W-1:0] quo_reg,
    output logic                      ovf_reg
);

    logic [DW-1:0] trial;

    assign trial = DW'(den_in) << SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_in >= trial)
            begin
                rem_reg <= rem_in - trial;
                quo_reg <= quo_in | (tmf_pkg::OUT_W'(1) << SH);
            end
            else
            begin
                rem_reg <= rem_in;
                quo_reg <= quo_in;
            end
            den_reg <= den_in;
            ovf_reg <= ovf_in;
        end
    end

endmodule

// ===== hw/rtl/tmf_lane.sv =====
`timescale 1ns / 1ps

// One mapping factor: sqrt cells, sine cells, divider cells
module tmf_lane #(
    parameter int          FRAC_BITS = tmf_pkg::FRAC_BITS_DEF,
    parameter logic [63:0] A2        = tmf_pkg::A2_DRY
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [35:0]               el_sq,
    output logic [tmf_pkg::OUT_W-1:0] mapping
);

    localparam int DW = (FRAC_BITS + 32 > 54) ? FRAC_BITS + 32 : 54;

    logic [63:0]        sq_v [0:tmf_pkg::SQRT_STEPS];
    logic [63:0]        sq_r [0:tmf_pkg::SQRT_STEPS];
    logic [31:0]        theta;
    logic [30:0]        x_next;
    logic [30:0]        x_reg;
    logic [61:0]        x_sq;
    tmf_pkg::sin_item_t sn_it [0:tmf_pkg::SIN_STEPS];
    logic [61:0]        sin_prod;
    logic [30:0]        sin_reg;
    logic [DW-1:0]      num;
    logic [DW-1:0]      lim;
    logic [DW-1:0]      dv_r [0:tmf_pkg::DIV_STEPS];
    logic [30:0]        dv_d [0:tmf_pkg::DIV_STEPS];
    logic [tmf_pkg::OUT_W-1:0] dv_q [0:tmf_pkg::DIV_STEPS];
    logic               dv_o [0:tmf_pkg::DIV_STEPS];

    // Square root of el^2 + a^2, one result bit per cell
    assign sq_v[0] = {el_sq, 28'd0} + A2;
    assign sq_r[0] = '0;

    genvar i;
    generate
        for (i = 0; i < tmf_pkg::SQRT_STEPS; i++)
        begin : g_sqrt
            tmf_sqrt_cell #(.BIT_POS(62 - 2 * i)) u_cell (
                .clk   (clk),
                .en    (en),
                .v_in  (sq_v[i]),
                .r_in  (sq_r[i]),
                .v_reg (sq_v[i+1]),
                .r_reg (sq_r[i+1])
            );
        end
    endgenerate

    // Fold angle into [0, pi/2]
    assign theta = sq_r[tmf_pkg::SQRT_STEPS][31:0];

    always_comb
    begin
        priority if (theta <= tmf_pkg::HALF_PI_Q30)
            x_next = theta[30:0];
        else if (theta < tmf_pkg::PI_Q30)
            x_next = 31'(tmf_pkg::PI_Q30 - theta);
        else
            x_next = '0;
    end

    // Square of folded angle, series starts at one
    assign x_sq = {31'd0, x_reg} * {31'd0, x_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_next;
            sn_it[0].x  <= x_reg;
            sn_it[0].x2 <= x_sq[61:30];
            sn_it[0].t  <= 31'd1 << 30;
        end
    end

    generate
        for (i = 0; i < tmf_pkg::SIN_STEPS; i++)
        begin : g_sin
            tmf_sin_cell #(.DIV_K(tmf_pkg::sin_div(i))) u_cell (
                .clk      (clk),
                .en       (en),
                .item_in  (sn_it[i]),
                .item_reg (sn_it[i+1])
            );
        end
    endgenerate

    // sin = x * t, then rounded numerator and overflow check
    assign sin_prod = {31'd0, sn_it[tmf_pkg::SIN_STEPS].x} * {31'd0, sn_it[tmf_pkg::SIN_STEPS].t};
    assign num      = (DW'(1) << (30 + FRAC_BITS)) + DW'(sin_reg >> 1);
    assign lim      = DW'(sin_reg) << tmf_pkg::DIV_STEPS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_prod[60:30];
            dv_r[0] <= num;
            dv_d[0] <= sin_reg;
            dv_q[0] <= '0;
            dv_o[0] <= (sin_reg == '0) || (num >= lim);
        end
    end

    generate
        for (i = 0; i < tmf_pkg::DIV_STEPS; i++)
        begin : g_div
            tmf_div_cell #(.DW(DW), .SH(tmf_pkg::DIV_STEPS - 1 - i)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (dv_r[i]),
                .den_in  (dv_d[i]),
                .quo_in  (dv_q[i]),
                .ovf_in  (dv_o[i]),
                .rem_reg (dv_r[i+1]),
                .den_reg (dv_d[i+1]),
                .quo_reg (dv_q[i+1]),
                .ovf_reg (dv_o[i+1])
            );
        end
    endgenerate

    assign mapping = dv_o[tmf_pkg::DIV_STEPS] ? tmf_pkg::OUT_MAX : dv_q[tmf_pkg::DIV_STEPS];

endmodule
